FILE: rtl/core/scba_pkg.sv
// Shared types, codes and class table for the size-class block allocator.
package scba_pkg;

	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NULL      = 2'd1;
	localparam logic [1:0] ST_DELEGATED = 2'd2;
	localparam logic [1:0] ST_EXHAUSTED = 2'd3;

	localparam int CLASS_MAX = 14;
	localparam int GRAN_W    = 16;
	localparam int ADDR_W    = 20;

	// Classified request handed from front to back.
	typedef struct packed {
		logic [1:0]        kind;   // ACT_* code as received, or the unused code
		logic [1:0]        status; // early status (null / delegated)
		logic              early;  // result known in front, no state change
		logic [3:0]        cls;
		logic [GRAN_W-1:0] gran;
	} req_t;

	function automatic logic [9:0] class_bytes(input logic [3:0] c);
		logic [9:0] b;
		case (c)
			4'd0: b = 10'd16;
			4'd1: b = 10'd32;
			4'd2: b = 10'd64;
			4'd3: b = 10'd96;
			4'd4: b = 10'd128;
			4'd5: b = 10'd160;
			4'd6: b = 10'd192;
			4'd7: b = 10'd224;
			4'd8: b = 10'd256;
			4'd9: b = 10'd320;
			4'd10: b = 10'd384;
			4'd11: b = 10'd448;
			4'd12: b = 10'd512;
			default: b = 10'd640;
		endcase
		return b;
	endfunction

endpackage

FILE: rtl/core/scba_front.sv
// Front end: accepts items, classifies size and queues requests.
module scba_front import scba_pkg::*; #(
	parameter int MAX_BLOCK_BYTES = 640,
	parameter int CLASS_COUNT = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [1:0]  action,
	input  logic [15:0] size,
	input  logic [19:0] block_address,
	output logic        q_valid,
	input  logic        q_ready,
	output req_t        q_data
);
	localparam int DEPTH = 2;

	req_t       fifo_q [DEPTH];
	logic [0:0] wr_q, rd_q;
	logic [1:0] cnt_q;
	req_t       req;
	logic [3:0] cls;
	logic       found;

	always_comb begin
		cls = 4'd0;
		found = 1'b0;
		for (int c = CLASS_MAX - 1; c >= 0; c--) begin
			if (c < CLASS_COUNT && size <= {6'd0, class_bytes(4'(c))}) begin
				cls = 4'(c);
				found = 1'b1;
			end
		end
		if ({16'd0, size} > 32'(MAX_BLOCK_BYTES)) found = 1'b0;
		req.kind = action;
		req.cls = cls;
		req.gran = block_address[19:4];
		req.early = 1'b0;
		req.status = ST_DONE;
		if (action == ACT_ALLOC || action == ACT_FREE) begin
			if (size == 16'd0) begin
				req.early = 1'b1;
				req.status = ST_NULL;
			end else if (!found) begin
				req.early = 1'b1;
				req.status = ST_DELEGATED;
			end
		end else if (action != ACT_CLEAR) begin
			req.early = 1'b1;
		end
	end

	assign ready = (cnt_q != 2'(DEPTH));
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (valid && ready) fifo_q[wr_q] <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (valid && ready) wr_q <= wr_q + 1'b1;
			if (q_valid && q_ready) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + 2'(valid && ready) - 2'(q_valid && q_ready);
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(DEPTH))
		else $error("queue count overflow");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'(DEPTH)) |-> !ready) else $error("ready while full");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !q_valid) else $error("valid while empty");
endmodule

FILE: rtl/core/scba_back.sv
// Back end: free lists, link memory, carving and chunk opening.
module scba_back import scba_pkg::*; #(
	parameter int NUM_CHUNKS = 64,
	parameter int CHUNK_BYTES = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  req_t        q_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [19:0] granted_address,
	output logic [1:0]  status
);
	localparam int CW = $clog2(NUM_CHUNKS + 1);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LINK = 2'd1;

	// Blocks left in a fresh chunk after its first block is handed out.
	localparam logic [9:0] LEFT_INIT [CLASS_MAX] = '{
		10'(CHUNK_BYTES / 16 - 1),  10'(CHUNK_BYTES / 32 - 1),
		10'(CHUNK_BYTES / 64 - 1),  10'(CHUNK_BYTES / 96 - 1),
		10'(CHUNK_BYTES / 128 - 1), 10'(CHUNK_BYTES / 160 - 1),
		10'(CHUNK_BYTES / 192 - 1), 10'(CHUNK_BYTES / 224 - 1),
		10'(CHUNK_BYTES / 256 - 1), 10'(CHUNK_BYTES / 320 - 1),
		10'(CHUNK_BYTES / 384 - 1), 10'(CHUNK_BYTES / 448 - 1),
		10'(CHUNK_BYTES / 512 - 1), 10'(CHUNK_BYTES / 640 - 1)
	};

	logic [16:0]      head_q [CLASS_MAX];
	logic [19:0]      next_q [CLASS_MAX];
	logic [9:0]       left_q [CLASS_MAX];
	logic [CW-1:0]    used_q;
	logic [16:0]      link_mem [2**GRAN_W];
	logic [16:0]      link_rd_q;
	logic [1:0]       state_q;
	logic [3:0]       pcls_q;
	logic             obusy_q;
	logic [19:0]      base;
	logic [9:0]       cb;
	logic [16:0]      hd;

	assign out_valid = obusy_q;
	assign q_ready = (state_q == S_IDLE) && (!obusy_q || out_ready);
	assign cb = class_bytes(q_data.cls);
	assign hd = head_q[q_data.cls];
	assign base = 20'(32'(used_q) * CHUNK_BYTES);

	// Link memory: free writes, pop reads (data ready next cycle).
	always_ff @(posedge clk) begin
		if (q_valid && q_ready && !q_data.early && q_data.kind == ACT_FREE)
			link_mem[q_data.gran] <= hd;
		link_rd_q <= link_mem[hd[15:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			obusy_q <= 1'b0;
			used_q <= '0;
			pcls_q <= 4'd0;
			granted_address <= '0;
			status <= ST_DONE;
			for (int i = 0; i < CLASS_MAX; i++) begin
				head_q[i] <= '0;
				next_q[i] <= '0;
				left_q[i] <= '0;
			end
		end else begin
			if (out_valid && out_ready) obusy_q <= 1'b0;
			unique case (state_q)
				S_LINK: begin
					head_q[pcls_q] <= link_rd_q;
					state_q <= S_IDLE;
				end
				default: begin
					if (q_valid && q_ready) begin
						obusy_q <= 1'b1;
						granted_address <= '0;
						status <= q_data.status;
						if (!q_data.early) begin
							case (q_data.kind)
								ACT_CLEAR: begin
									used_q <= '0;
									for (int i = 0; i < CLASS_MAX; i++) begin
										head_q[i] <= '0;
										next_q[i] <= '0;
										left_q[i] <= '0;
									end
								end
								ACT_FREE: head_q[q_data.cls] <= {1'b1, q_data.gran};
								default: begin
									if (hd[16]) begin
										granted_address <= {hd[15:0], 4'd0};
										pcls_q <= q_data.cls;
										state_q <= S_LINK;
									end else if (left_q[q_data.cls] != 10'd0) begin
										granted_address <= next_q[q_data.cls];
										next_q[q_data.cls] <= next_q[q_data.cls] + 20'(cb);
										left_q[q_data.cls] <= left_q[q_data.cls] - 10'd1;
									end else if (32'(used_q) < NUM_CHUNKS) begin
										granted_address <= base;
										next_q[q_data.cls] <= base + 20'(cb);
										left_q[q_data.cls] <= LEFT_INIT[q_data.cls];
										used_q <= used_q + CW'(1);
									end else begin
										status <= ST_EXHAUSTED;
									end
								end
							endcase
						end
					end
				end
			endcase
		end
	end

	a_link: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LINK) |=> (state_q == S_IDLE)) else $error("link state stuck");
	a_noacc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LINK) |-> !q_ready) else $error("accept during link read");
	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= NUM_CHUNKS) else $error("chunk count overflow");
endmodule

FILE: rtl/core/size_class_block_allocator_core.sv
// Top level of the size-class block allocator.
// Usage:
//  - Input channel valid/ready carries action, size, block_address.
//    action: 0 allocate, 1 free, 2 clear. One result per item.
//  - Output channel out_valid/out_ready carries granted_address, status.
//  - Front classifies size into a class and writes a two-entry queue;
//    back executes against per-class list heads, carve pointers and a
//    64K-entry link memory.
//  - Each item is written into the queue, then its result is registered.
//  - Throughput: one item per cycle for free, clear, carve and new chunk
//    while out_ready holds; an allocate that pops a free list adds a link
//    state, which takes the next head from the registered link-memory read.
//  - Reset clears all lists, carve state and chunk count at once; the link
//    memory is not cleared (always written before read).
//  - When the receiver stalls, the result register holds and the queue
//    fills; ready drops once the queue is full.
module size_class_block_allocator_core import scba_pkg::*; #(
	parameter int NUM_CHUNKS = 64,
	parameter int CHUNK_BYTES = 16384,
	parameter int MAX_BLOCK_BYTES = 640,
	parameter int CLASS_COUNT = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [1:0]  action,
	input  logic [15:0] size,
	input  logic [19:0] block_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [19:0] granted_address,
	output logic [1:0]  status
);
	logic q_valid, q_ready;
	req_t q_data;

	scba_front #(.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES), .CLASS_COUNT(CLASS_COUNT)) u_front (
		.clk, .arst_n, .valid, .ready, .action, .size, .block_address,
		.q_valid, .q_ready, .q_data
	);

	scba_back #(.NUM_CHUNKS(NUM_CHUNKS), .CHUNK_BYTES(CHUNK_BYTES)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_data,
		.out_valid, .out_ready, .granted_address, .status
	);
endmodule

FILE: tb/scba_checker.sv
// Checker for the size-class block allocator: predicts each result and compares it.
module scba_checker import scba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	input  logic        ready,
	input  logic [1:0]  action,
	input  logic [15:0] size,
	input  logic [19:0] block_address,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [19:0] granted_address,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          pending_count,
	output int          result_count
);
	localparam int POOL_CHUNKS = 64;
	localparam int CHUNK_SZ    = 16384;
	localparam int BLOCK_MAX   = 640;

	typedef struct packed {
		logic [19:0] grant;
		logic [1:0]  st;
	} grant_t;

	logic [16:0] head_q [CLASS_MAX];
	logic [16:0] next_link [int];
	logic [19:0] carve_ptr [CLASS_MAX];
	logic [9:0]  carve_cnt [CLASS_MAX];
	int          opened;
	grant_t      expected_grants [$];

	function automatic logic [9:0] class_size(input int c);
		case (c)
			0: return 10'd16;   1: return 10'd32;   2: return 10'd64;   3: return 10'd96;
			4: return 10'd128;  5: return 10'd160;  6: return 10'd192;  7: return 10'd224;
			8: return 10'd256;  9: return 10'd320;  10: return 10'd384; 11: return 10'd448;
			12: return 10'd512; default: return 10'd640;
		endcase
	endfunction

	function automatic int size_to_class(input logic [15:0] sz);
		if (sz > BLOCK_MAX)
			return -1;
		for (int c = 0; c < CLASS_MAX; c++)
			if (sz <= {6'd0, class_size(c)})
				return c;
		return -1;
	endfunction

	task automatic wipe_pool();
		for (int c = 0; c < CLASS_MAX; c++) begin
			head_q[c] = '0;
			carve_ptr[c] = '0;
			carve_cnt[c] = '0;
		end
		opened = 0;
	endtask

	task automatic predict_grant(input logic [1:0] act, input logic [15:0] sz,
			input logic [19:0] addr);
		grant_t r;
		int c;
		logic [15:0] g;
		r = '0;
		if (act == ACT_CLEAR) begin
			wipe_pool();
		end else if (act == ACT_ALLOC || act == ACT_FREE) begin
			c = size_to_class(sz);
			if (sz == 0) begin
				r.st = ST_NULL;
			end else if (c < 0) begin
				r.st = ST_DELEGATED;
			end else if (act == ACT_FREE) begin
				g = addr[19:4];
				next_link[g] = head_q[c];
				head_q[c] = {1'b1, g};
			end else if (head_q[c][16]) begin
				g = head_q[c][15:0];
				r.grant = {g, 4'h0};
				head_q[c] = next_link.exists(g) ? next_link[g] : '0;
			end else if (carve_cnt[c] != 0) begin
				r.grant = carve_ptr[c];
				carve_ptr[c] = carve_ptr[c] + 20'(class_size(c));
				carve_cnt[c] = carve_cnt[c] - 10'd1;
			end else if (opened < POOL_CHUNKS) begin
				r.grant = 20'(opened * CHUNK_SZ);
				carve_ptr[c] = r.grant + 20'(class_size(c));
				carve_cnt[c] = 10'(CHUNK_SZ / int'(class_size(c)) - 1);
				opened++;
			end else begin
				r.st = ST_EXHAUSTED;
			end
		end
		expected_grants.push_back(r);
	endtask

	initial begin
		wipe_pool();
		fail_count = 0;
		result_count = 0;
	end

	assign pending_count = expected_grants.size();

	always @(posedge clk) begin
		grant_t e;
		if (arst_n) begin
			if (valid && ready)
				predict_grant(action, size, block_address);
			if (out_valid && out_ready) begin
				result_count++;
				if (expected_grants.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result addr=%h st=%0d", granted_address, status);
				end else begin
					e = expected_grants.pop_front();
					if (e.grant !== granted_address || e.st !== status) begin
						fail_count++;
						if (fail_count <= 10)
							$display("result %0d: expected addr=%h st=%0d, got addr=%h st=%0d",
								result_count, e.grant, e.st, granted_address, status);
					end
				end
			end
		end
	end
endmodule

FILE: tb/tb.sv
// Testbench top for the size-class block allocator: stimulus and verdict.
module tb;
	import scba_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        valid = 0;
	logic        ready;
	logic [1:0]  action = ACT_CLEAR;
	logic [15:0] size = 0;
	logic [19:0] block_address = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [19:0] granted_address;
	logic [1:0]  status;
	int          fail_count, pending_count, result_count;

	// Sender idles ~30% unless quiet; receiver likewise, plus one long hold-off.
	bit          quiet = 0;
	bit          hold_off = 0;
	int          items_sent = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	size_class_block_allocator_core dut (.*);

	scba_checker chk (.*);

	// Receiver: random stalls, none while quiet, and a full stall while hold_off is set.
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 0;
		else if (hold_off)
			out_ready <= 0;
		else
			out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 30);
	end

	// Valid drops only while idling, so it stays high across back-to-back items.
	task automatic send_item(input logic [1:0] a, input logic [15:0] s,
			input logic [19:0] addr);
		if (!quiet)
			while ($urandom_range(99) < 30) begin
				valid <= 0;
				@(posedge clk);
			end
		valid <= 1;
		action <= a;
		size <= s;
		block_address <= addr;
		@(posedge clk);
		while (!ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Wait until every result has come back, then let the pipe drain.
	task automatic drain();
		valid <= 0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Random size biased toward the enabled classes with some edge values.
	function automatic logic [15:0] pick_size();
		case ($urandom_range(9))
			0: return 16'($urandom);
			1: return 16'd0;
			2: return 16'(640 + $urandom_range(1, 3));
			default: return 16'($urandom_range(1, 640));
		endcase
	endfunction

	initial begin
		logic [15:0] s;
		logic [19:0] a;
		int k;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: null, delegated, class edges, unaligned and foreign frees.
		send_item(ACT_ALLOC, 0, 0);
		send_item(ACT_FREE, 0, 20'hFFFFF);
		send_item(ACT_ALLOC, 16'hFFFF, 0);
		send_item(ACT_ALLOC, 641, 0);
		send_item(ACT_FREE, 641, 0);
		send_item(ACT_ALLOC, 1, 0);
		send_item(ACT_ALLOC, 16, 0);
		send_item(ACT_ALLOC, 17, 0);
		send_item(ACT_ALLOC, 640, 0);
		send_item(ACT_FREE, 16, 20'h0000F);      // unaligned
		send_item(ACT_FREE, 16, 20'hFFFF0);      // foreign block
		send_item(ACT_ALLOC, 16, 0);
		send_item(ACT_ALLOC, 16, 0);
		send_item(ACT_ALLOC, 16, 0);
		send_item(2'd3, 16'hFFFF, 20'hFFFFF);    // unused code
		send_item(ACT_CLEAR, 0, 0);
		send_item(ACT_ALLOC, 640, 0);
		// Exhaust the pool: each 640-byte class chunk holds 25 blocks, so the
		// 64 chunks run out just before the end of this loop.
		for (k = 0; k < 64 * 25; k++) begin
			if (k == 200)
				quiet = 1;
			if (k == 400)
				quiet = 0;
			if (k == 700) begin
				hold_off = 1;
				fork
					begin
						repeat (60) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			send_item(ACT_ALLOC, 16'(513 + k % 128), 0);
		end
		send_item(ACT_ALLOC, 640, 0);
		drain();
		send_item(ACT_CLEAR, 0, 0);

		// Random: mostly alloc, plus frees of random addresses, clears and unused codes.
		for (k = 0; k < 120; k++) begin
			s = pick_size();
			a = 20'($urandom);
			case ($urandom_range(19))
				0: send_item(ACT_CLEAR, 16'($urandom), 20'($urandom));
				1: send_item(2'd3, 16'($urandom), a);
				2, 3, 4, 5, 6, 7: send_item(ACT_FREE, s, a);
				default: send_item(ACT_ALLOC, s, a);
			endcase
		end
		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d items, checked %0d results across null, oversize, pop, carve,",
			items_sent, result_count);
		$display("new chunk, exhaustion, clear and a long receiver stall.");
		if (fail_count == 0 && pending_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end
endmodule
